[design/hsv_pkg.sv]
// Shared types and constants for the HSV to RGB converter.
`default_nettype none

package hsv_pkg;

	localparam int HUE_W     = 13;
	localparam int UNIT_W    = 9;
	localparam int LEVEL_W   = 8;
	localparam int SCALE_W   = 16;
	localparam int SECTOR_W  = 3;
	localparam int REM_W     = 10;
	localparam int PROD_W    = 18;
	localparam int NUM_W     = SCALE_W + PROD_W;
	localparam int QUOT_W    = 12;
	localparam int PV_W      = SCALE_W + UNIT_W;
	localparam int RECIP_W   = 13;
	localparam int DIV15_W   = 2 * RECIP_W;
	localparam int DIV15_SH  = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [HUE_W-1:0]   HUE_FULL   = 13'd5760;
	localparam logic [HUE_W-1:0]   HUE_SECTOR = 13'd960;
	localparam logic [UNIT_W-1:0]  UNIT_ONE   = 9'd256;
	localparam logic [PROD_W-1:0]  PROD_FULL  = 18'd245760;
	localparam logic [RECIP_W-1:0] RECIP_15   = 13'd4369;

	typedef logic [SECTOR_W-1:0]  sector_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam sector_t SECTOR_0 = 3'd0;
	localparam sector_t SECTOR_1 = 3'd1;
	localparam sector_t SECTOR_2 = 3'd2;
	localparam sector_t SECTOR_3 = 3'd3;
	localparam sector_t SECTOR_4 = 3'd4;
	localparam sector_t SECTOR_5 = 3'd5;
	localparam int      SECTOR_COUNT = 6;

	localparam cfg_idx_t REG_SATURATION = 2'd0;
	localparam cfg_idx_t REG_BRIGHTNESS = 2'd1;

	typedef struct packed {
		logic [UNIT_W-1:0]  sat;
		logic [SCALE_W-1:0] scale;
	} cfg_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

`default_nettype wire

[design/hsv_cfg_regs.sv]
// Saturation and brightness registers with clamping and brightness scaling.
`default_nettype none

module hsv_cfg_regs
	import hsv_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire cfg_idx_t          cfg_index,
	input  wire logic [UNIT_W-1:0] cfg_data,
	output cfg_t                   cfg
);

	logic [UNIT_W-1:0]  unit_c;
	logic [SCALE_W-1:0] scale_c;
	logic [UNIT_W-1:0]  sat_q;
	logic [SCALE_W-1:0] scale_q;

	always_comb begin
		unit_c  = (cfg_data > UNIT_ONE) ? UNIT_ONE : cfg_data;
		scale_c = SCALE_W'({unit_c, 8'd0} - {8'd0, unit_c});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q   <= UNIT_ONE;
			scale_q <= SCALE_W'({UNIT_ONE, 8'd0} - {8'd0, UNIT_ONE});
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SATURATION: sat_q <= unit_c;
				REG_BRIGHTNESS: scale_q <= scale_c;
				default: ;
			endcase
		end
	end

	assign cfg.sat   = sat_q;
	assign cfg.scale = scale_q;

endmodule

`default_nettype wire

[design/hsv_pipe_ctrl.sv]
// Valid bits and stage enables of the four-stage converter pipeline.
`default_nettype none

module hsv_pipe_ctrl
	import hsv_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output stage_en_t en
);

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;

	always_comb begin
		en.s4 = !valid_s4 || out_ready;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en.s1) begin
				valid_s1 <= in_valid;
			end
			if (en.s2) begin
				valid_s2 <= valid_s1;
			end
			if (en.s3) begin
				valid_s3 <= valid_s2;
			end
			if (en.s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	assign in_ready  = en.s1;
	assign out_valid = valid_s4;

endmodule

`default_nettype wire

[design/hsv_datapath.sv]
// Sector split, level arithmetic and channel routing of the converter.
`default_nettype none

module hsv_datapath
	import hsv_pkg::*;
(
	input  wire logic             clk,
	input  wire stage_en_t        en,
	input  wire cfg_t             cfg,
	input  wire logic [HUE_W-1:0] hue_sixteenths,
	output logic [LEVEL_W-1:0]    red_level,
	output logic [LEVEL_W-1:0]    green_level,
	output logic [LEVEL_W-1:0]    blue_level
);

	logic [HUE_W-1:0]   hue_c;
	sector_t            sector_c;
	logic [HUE_W-1:0]   base_c;
	logic [REM_W-1:0]   rem_c;

	sector_t            sector_s1;
	logic [REM_W-1:0]   rem_s1;

	logic [PROD_W-1:0]  prod_q_c;
	logic [PROD_W-1:0]  prod_t_c;
	sector_t            sector_s2;
	logic [PROD_W-1:0]  prod_q_s2;
	logic [PROD_W-1:0]  prod_t_s2;

	logic [NUM_W-1:0]   full_q_c;
	logic [NUM_W-1:0]   full_t_c;
	logic [PV_W-1:0]    full_p_c;
	sector_t            sector_s3;
	logic [QUOT_W-1:0]  quot_q_s3;
	logic [QUOT_W-1:0]  quot_t_s3;
	logic [LEVEL_W-1:0] lvl_p_s3;
	logic [LEVEL_W-1:0] lvl_v_s3;

	logic [DIV15_W-1:0] div_q_c;
	logic [DIV15_W-1:0] div_t_c;
	logic [LEVEL_W-1:0] lvl_q_c;
	logic [LEVEL_W-1:0] lvl_t_c;
	logic [LEVEL_W-1:0] red_s4;
	logic [LEVEL_W-1:0] green_s4;
	logic [LEVEL_W-1:0] blue_s4;

	// Stage one: saturate the hue and split it into sector and remainder.
	always_comb begin
		hue_c    = (hue_sixteenths > HUE_FULL) ? HUE_FULL : hue_sixteenths;
		sector_c = SECTOR_0;
		for (int i = 1; i < SECTOR_COUNT; i++) begin
			if (hue_c >= HUE_W'(i) * HUE_SECTOR) begin
				sector_c = SECTOR_W'(i);
			end
		end
		if (hue_c == HUE_FULL) begin
			sector_c = SECTOR_0;
		end
		base_c = HUE_W'(sector_c) * HUE_SECTOR;
		rem_c  = (hue_c == HUE_FULL) ? '0 : REM_W'(hue_c - base_c);
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			sector_s1 <= sector_c;
			rem_s1    <= rem_c;
		end
	end

	// Stage two: saturation times remainder and times its complement.
	always_comb begin
		prod_q_c = PROD_W'(cfg.sat) * PROD_W'(rem_s1);
		prod_t_c = PROD_W'(cfg.sat) * (PROD_W'(HUE_SECTOR) - PROD_W'(rem_s1));
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			sector_s2 <= sector_s1;
			prod_q_s2 <= prod_q_c;
			prod_t_s2 <= prod_t_c;
		end
	end

	// Stage three: scale by brightness and drop the power-of-two part of the divisor.
	always_comb begin
		full_q_c = NUM_W'(cfg.scale) * NUM_W'(PROD_FULL - prod_q_s2);
		full_t_c = NUM_W'(cfg.scale) * NUM_W'(PROD_FULL - prod_t_s2);
		full_p_c = PV_W'(cfg.scale) * PV_W'(UNIT_ONE - cfg.sat);
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			sector_s3 <= sector_s2;
			quot_q_s3 <= full_q_c[NUM_W-1 -: QUOT_W];
			quot_t_s3 <= full_t_c[NUM_W-1 -: QUOT_W];
			lvl_p_s3  <= full_p_c[SCALE_W +: LEVEL_W];
			lvl_v_s3  <= cfg.scale[SCALE_W-1 -: LEVEL_W];
		end
	end

	// Stage four: exact division by fifteen through a reciprocal, then routing.
	always_comb begin
		div_q_c = (DIV15_W'(quot_q_s3) + DIV15_W'(1)) * DIV15_W'(RECIP_15);
		div_t_c = (DIV15_W'(quot_t_s3) + DIV15_W'(1)) * DIV15_W'(RECIP_15);
		lvl_q_c = div_q_c[DIV15_SH +: LEVEL_W];
		lvl_t_c = div_t_c[DIV15_SH +: LEVEL_W];
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			case (sector_s3)
				SECTOR_1: begin
					red_s4   <= lvl_q_c;
					green_s4 <= lvl_v_s3;
					blue_s4  <= lvl_p_s3;
				end
				SECTOR_2: begin
					red_s4   <= lvl_p_s3;
					green_s4 <= lvl_v_s3;
					blue_s4  <= lvl_t_c;
				end
				SECTOR_3: begin
					red_s4   <= lvl_p_s3;
					green_s4 <= lvl_q_c;
					blue_s4  <= lvl_v_s3;
				end
				SECTOR_4: begin
					red_s4   <= lvl_t_c;
					green_s4 <= lvl_p_s3;
					blue_s4  <= lvl_v_s3;
				end
				SECTOR_5: begin
					red_s4   <= lvl_v_s3;
					green_s4 <= lvl_p_s3;
					blue_s4  <= lvl_q_c;
				end
				default: begin
					red_s4   <= lvl_v_s3;
					green_s4 <= lvl_t_c;
					blue_s4  <= lvl_p_s3;
				end
			endcase
		end
	end

	assign red_level   = red_s4;
	assign green_level = green_s4;
	assign blue_level  = blue_s4;

endmodule

`default_nettype wire

[design/hsv_to_rgb_converter_unit.sv]
// Top level of the HSV to RGB converter.
// An accepted request reaches the outputs through the stage registers s1 to s4.
// Throughput is one request per cycle unless the output stalls; the four-stage pipeline sets this figure.
// A stall at the output holds the result and fills empty stages before input backs up.
// Reset clears all valid bits and sets saturation and brightness to 1.0.
`default_nettype none

module hsv_to_rgb_converter_unit
	import hsv_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire cfg_idx_t           cfg_index,
	input  wire logic [UNIT_W-1:0]  cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [HUE_W-1:0]   hue_sixteenths,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [LEVEL_W-1:0]      red_level,
	output logic [LEVEL_W-1:0]      green_level,
	output logic [LEVEL_W-1:0]      blue_level
);

	cfg_t      cfg;
	stage_en_t en;

	hsv_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hsv_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.en        (en)
	);

	hsv_datapath u_dp (
		.clk            (clk),
		.en             (en),
		.cfg            (cfg),
		.hue_sixteenths (hue_sixteenths),
		.red_level      (red_level),
		.green_level    (green_level),
		.blue_level     (blue_level)
	);

endmodule

`default_nettype wire

[design/hsv_checker.sv]
// Port-level checks of the HSV to RGB converter and their binding.
`default_nettype none

module hsv_checker
	import hsv_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [LEVEL_W-1:0] red_level,
	input wire logic [LEVEL_W-1:0] green_level,
	input wire logic [LEVEL_W-1:0] blue_level
);

	// A result that is not taken stays on the outputs unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red_level)
			&& $stable(green_level) && $stable(blue_level))
		else $error("stalled result changed");

	// With the output stage free or draining, the pipeline takes a request.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input blocked while output stage can move");

	// Without stalls, out_valid follows each accepted request through the pipeline stages.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n, 4) && $past(arst_n, 3) && $past(arst_n, 2) && $past(arst_n, 1)
			&& $past(out_ready, 1) && $past(out_ready, 2) && $past(out_ready, 3)
			&& $past(out_ready, 4)
			|-> out_valid == $past(in_valid && in_ready, 4))
		else $error("result timing differs from four-cycle latency");

endmodule

bind hsv_to_rgb_converter_unit hsv_checker u_hsv_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.red_level   (red_level),
	.green_level (green_level),
	.blue_level  (blue_level)
);

`default_nettype wire
